FILE: hw/rtl/crs_pkg.sv
// Shared types and constants of the CCD readout clock sequencer.
// Used by the controller, the datapath and the top level.
`default_nettype none
package crs_pkg;

    localparam int unsigned DEF_MAX_COLUMNS       = 2048;
    localparam int unsigned DEF_MAX_ROWS          = 4096;
    localparam int unsigned DEF_FLUSH_GROUP_LINES = 32;
    localparam int unsigned DEF_PHASE_REPEAT      = 4;

    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_COLUMNS     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_ROWS        = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_COLUMNS_BEGIN = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_COLUMNS_END   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ROWS_BEGIN    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ROWS_END      = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COLUMNS        = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_ROWS           = 4'd7;

    localparam logic [1:0] FUNC_STEP  = 2'd0;
    localparam logic [1:0] FUNC_FLUSH = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    // segment codes of the sequence
    localparam logic [2:0] PH_FLUSH_SHIFT = 3'd0;
    localparam logic [2:0] PH_FLUSH_LINE  = 3'd1;
    localparam logic [2:0] PH_DEAD_SHIFT  = 3'd2;
    localparam logic [2:0] PH_DEAD_LINE   = 3'd3;
    localparam logic [2:0] PH_ROW_SHIFT   = 3'd4;
    localparam logic [2:0] PH_DCB         = 3'd5;
    localparam logic [2:0] PH_PIXEL       = 3'd6;
    localparam logic [2:0] PH_DCE         = 3'd7;

    localparam logic [15:0] PIX_XOR = 16'h8888;
    localparam logic [15:0] PIX_MAX = 16'd32767;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_FLUSH,
        MODE_READ
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SETTLE
    } t_state;

    typedef struct packed {
        logic start;
        logic emit_plain;
        logic div_finish;
        logic step;
        logic advance;
        logic emit_write;
        logic emit_done;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic div_busy;
        logic fin;
        logic ready;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

FILE: hw/rtl/ccd_readout_clock_sequencer.sv
// Top level of the CCD readout clock sequencer.
// Joins crs_ctrl and crs_dp; uses crs_pkg.
`default_nettype none
// Each input word gives one result word. A step word is accepted from the
// idle state; the settle state then walks past any empty segments (when dead
// columns or rows are zero) before the write or done result is registered.
// A start word runs the bit-serial dividers that form the output row and
// column counts; the flush group count comes from a reciprocal multiply at
// the start. Ignored words and steps while idle get a plain result straight
// from the idle state. Configuration is latched when a flush or readout starts.
module ccd_readout_clock_sequencer #(
    parameter int unsigned MAX_COLUMNS       = crs_pkg::DEF_MAX_COLUMNS,
    parameter int unsigned MAX_ROWS          = crs_pkg::DEF_MAX_ROWS,
    parameter int unsigned FLUSH_GROUP_LINES = crs_pkg::DEF_FLUSH_GROUP_LINES,
    parameter int unsigned PHASE_REPEAT      = crs_pkg::DEF_PHASE_REPEAT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [crs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [crs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [1:0]                     i_func,
    input  wire logic [7:0]                     i_status_byte,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_port_write,
    output logic [7:0]                          o_port_byte,
    output logic                                o_pixel_valid,
    output logic [14:0]                         o_pixel_value,
    output logic [22:0]                         o_pixel_index,
    output logic                                o_busy_res,
    output logic                                o_sequence_done
);
    import crs_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    crs_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .i_func,
        .i_stat(stat), .o_in_stall, .o_cmd(cmd)
    );

    crs_dp #(
        .MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS),
        .FLUSH_GROUP_LINES(FLUSH_GROUP_LINES), .PHASE_REPEAT(PHASE_REPEAT)
    ) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_stat(stat),
        .i_cfg_we, .i_cfg_index, .i_cfg_data, .i_func, .i_status_byte,
        .i_out_stall, .o_out_valid, .o_port_write, .o_port_byte,
        .o_pixel_valid, .o_pixel_value, .o_pixel_index, .o_busy_res,
        .o_sequence_done
    );

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("word accepted while result held");

    a_write_xor_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_port_write && o_sequence_done))
        else $error("write and done in one result");

    a_pixel_on_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pixel_valid) |-> ((o_port_write || o_sequence_done) && o_busy_res))
        else $error("pixel outside a sequence step");
endmodule
`default_nettype wire

FILE: hw/rtl/crs_div.sv
// Restoring divider, one quotient bit per cycle.
// Stand-alone; used by the sequencer datapath for the start-up divisions.
`default_nettype none
module crs_div #(
    parameter int unsigned DW = 14,
    parameter int unsigned VW = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output logic      [DW-1:0] o_quot,
    output logic               o_busy
);
    localparam int unsigned CNT_W = $clog2(DW + 1);

    logic [VW-1:0]    r_rem;
    logic [DW-1:0]    r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic [VW:0]      trial;
    logic             ge;

    assign trial  = {r_rem, r_quo[DW-1]};
    assign ge     = trial >= {1'b0, i_divisor};
    assign o_quot = r_quo;
    assign o_busy = r_cnt != '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(DW);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (o_busy) begin
            r_rem <= ge ? VW'(trial - {1'b0, i_divisor}) : trial[VW-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/crs_dp.sv
// Datapath of the sequencer: configuration, counters, byte patterns,
// pixel rebuild and the output register. Uses crs_pkg and crs_div.
`default_nettype none
module crs_dp #(
    parameter int unsigned MAX_COLUMNS       = crs_pkg::DEF_MAX_COLUMNS,
    parameter int unsigned MAX_ROWS          = crs_pkg::DEF_MAX_ROWS,
    parameter int unsigned FLUSH_GROUP_LINES = crs_pkg::DEF_FLUSH_GROUP_LINES,
    parameter int unsigned PHASE_REPEAT      = crs_pkg::DEF_PHASE_REPEAT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire crs_pkg::t_cmd                     i_cmd,
    output crs_pkg::t_stat                         o_stat,
    input  wire logic                              i_cfg_we,
    input  wire logic [crs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [crs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic [1:0]                        i_func,
    input  wire logic [7:0]                        i_status_byte,
    input  wire logic                              i_out_stall,
    output logic                                   o_out_valid,
    output logic                                   o_port_write,
    output logic [7:0]                             o_port_byte,
    output logic                                   o_pixel_valid,
    output logic [14:0]                            o_pixel_value,
    output logic [22:0]                            o_pixel_index,
    output logic                                   o_busy_res,
    output logic                                   o_sequence_done
);
    import crs_pkg::*;

    localparam int unsigned SHIFT_WRITES = 5 * PHASE_REPEAT;
    // reciprocal of the group size; exact for dividends below 2^14, groups up to 64
    localparam int unsigned GRP_SHIFT = 20;
    localparam int unsigned GRP_RECIP =
        ((1 << GRP_SHIFT) + FLUSH_GROUP_LINES - 1) / FLUSH_GROUP_LINES;

    // configuration
    logic [11:0] r_cfg_cols;
    logic [12:0] r_cfg_rows;
    logic [7:0]  r_cfg_dcb, r_cfg_dce, r_cfg_drb, r_cfg_dre;
    logic [4:0]  r_cfg_binx, r_cfg_biny;

    // values latched at start; the output counts when the dividers finish
    logic [12:0] r_width;
    logic [13:0] r_groups;
    logic [4:0]  r_binx, r_biny;
    logic [7:0]  r_dcb, r_dce, r_drb;
    logic [11:0] r_ocols;
    logic [12:0] r_orows;

    // sequence state
    t_mode       r_mode;
    logic [2:0]  r_phase;
    logic [6:0]  r_ws;
    logic [3:0]  r_sub;
    logic [2:0]  r_pat;
    logic [2:0]  r_rc;
    logic [13:0] r_row, r_col;
    logic [11:0] r_nib;
    logic [13:0] r_pend_row, r_pend_col;

    // pixel of the current step
    logic        r_pv;
    logic [14:0] r_pval;
    logic [22:0] r_pidx;

    // output register
    logic        r_ovalid, r_owrite, r_opv, r_obusy, r_odone;
    logic [7:0]  r_obyte;
    logic [14:0] r_opval;
    logic [22:0] r_opidx;

    logic [12:0] cols_sat;
    logic [13:0] rows_sat;
    logic [13:0] flush_sum;
    logic [34:0] grp_prod;
    logic [13:0] q_cols, q_rows, q_grp;
    logic        b_cols, b_rows;
    logic [13:0] units;
    logic [6:0]  uwrites;
    logic [6:0]  pix_base;
    logic [6:0]  ws_inc;
    logic [6:0]  conv_off;
    logic [7:0]  byte_now;
    logic        fin, skip_dead;
    logic [3:0]  nib;
    logic [15:0] pix_raw;
    logic [13:0] mul_a;
    logic [25:0] prod;
    logic [22:0] idx;

    assign cols_sat  = ({1'b0, r_cfg_cols} > 13'(MAX_COLUMNS)) ? 13'(MAX_COLUMNS)
                                                              : {1'b0, r_cfg_cols};
    assign rows_sat  = ({1'b0, r_cfg_rows} > 14'(MAX_ROWS)) ? 14'(MAX_ROWS)
                                                           : {1'b0, r_cfg_rows};
    assign flush_sum = rows_sat + {6'd0, r_cfg_drb} + {6'd0, r_cfg_dre};
    assign grp_prod  = 35'(flush_sum) * 35'(GRP_RECIP);
    assign q_grp     = grp_prod[GRP_SHIFT +: 14];

    crs_div #(.DW(14), .VW(7)) u_div_cols (
        .i_clk, .i_rst_n, .i_start(i_cmd.start),
        .i_dividend({1'b0, cols_sat}), .i_divisor({2'd0, r_binx}),
        .o_quot(q_cols), .o_busy(b_cols)
    );
    crs_div #(.DW(14), .VW(7)) u_div_rows (
        .i_clk, .i_rst_n, .i_start(i_cmd.start),
        .i_dividend(rows_sat), .i_divisor({2'd0, r_biny}),
        .o_quot(q_rows), .o_busy(b_rows)
    );

    // units in the current segment and writes per unit
    always_comb begin
        case (r_phase)
            PH_FLUSH_SHIFT: units = 14'(FLUSH_GROUP_LINES);
            PH_FLUSH_LINE:  units = {1'b0, r_width};
            PH_DEAD_SHIFT:  units = 14'd1;
            PH_DEAD_LINE:   units = {r_width, 1'b0};
            PH_ROW_SHIFT:   units = {9'd0, r_biny};
            PH_DCB:         units = {6'd0, r_dcb};
            PH_PIXEL:       units = {2'd0, r_ocols};
            default:        units = {6'd0, r_dce};
        endcase
    end

    assign pix_base = 7'd8 + {1'b0, r_binx, 1'b0};
    assign conv_off = r_ws - pix_base;

    always_comb begin
        case (r_phase)
            PH_FLUSH_SHIFT, PH_DEAD_SHIFT, PH_ROW_SHIFT: uwrites = 7'(SHIFT_WRITES);
            PH_FLUSH_LINE:  uwrites = 7'd2;
            PH_PIXEL:       uwrites = 7'd12 + {1'b0, r_binx, 1'b0};
            default:        uwrites = 7'd3;
        endcase
    end

    always_comb begin
        byte_now = 8'hFB;
        case (r_phase)
            PH_FLUSH_SHIFT, PH_DEAD_SHIFT, PH_ROW_SHIFT: begin
                case (r_pat)
                    3'd1, 3'd3: byte_now = 8'hFA;
                    3'd2:       byte_now = 8'hF9;
                    default:    byte_now = 8'hFB;
                endcase
            end
            PH_FLUSH_LINE: byte_now = r_ws[0] ? 8'hFB : 8'hFF;
            PH_PIXEL: begin
                if (r_ws < 7'd5) begin
                    case (r_ws[2:0])
                        3'd0:    byte_now = 8'd247;
                        3'd4:    byte_now = 8'd239;
                        default: byte_now = 8'd255;
                    endcase
                end else if (r_ws < 7'd5 + {1'b0, r_binx, 1'b0}) begin
                    byte_now = r_ws[0] ? 8'd255 : 8'd251;
                end else if (r_ws < pix_base) begin
                    byte_now = 8'd251;
                end else begin
                    case (conv_off[1:0])
                        2'd0:    byte_now = 8'd219;
                        2'd1:    byte_now = 8'd91;
                        2'd2:    byte_now = 8'd155;
                        default: byte_now = 8'd27;
                    endcase
                end
            end
            default: begin
                case (r_ws[1:0])
                    2'd0:    byte_now = 8'hF7;
                    2'd1:    byte_now = 8'hFF;
                    default: byte_now = 8'hFB;
                endcase
            end
        endcase
    end

    assign fin = (r_mode == MODE_FLUSH && r_row >= r_groups)
              || (r_mode == MODE_READ && r_phase >= PH_ROW_SHIFT && r_row >= {1'b0, r_orows});
    assign skip_dead = r_mode == MODE_READ && r_phase <= PH_DEAD_LINE
                    && r_row >= {6'd0, r_drb};
    assign ws_inc = r_ws + 7'd1;

    assign nib     = i_status_byte[7:4];
    assign pix_raw = {nib, r_nib} ^ PIX_XOR;
    assign mul_a   = (r_pend_col == '0) ? r_pend_row - 14'd1 : r_pend_row + 14'd1;
    assign prod    = mul_a * r_ocols;
    assign idx     = 23'(prod - ((r_pend_col == '0) ? 26'd0 : {12'd0, r_pend_col}));

    assign o_stat.active   = r_mode != MODE_IDLE;
    assign o_stat.div_busy = b_cols | b_rows;
    assign o_stat.fin      = fin;
    assign o_stat.ready    = !fin && !skip_dead && r_col < units;
    assign o_stat.out_free = !r_ovalid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= 12'd768;
            r_cfg_rows <= 13'd512;
            r_cfg_dcb  <= 8'd14;
            r_cfg_dce  <= 8'd14;
            r_cfg_drb  <= 8'd4;
            r_cfg_dre  <= 8'd4;
            r_cfg_binx <= 5'd1;
            r_cfg_biny <= 5'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SENSOR_COLUMNS:     r_cfg_cols <= i_cfg_data[11:0];
                CFG_SENSOR_ROWS:        r_cfg_rows <= i_cfg_data;
                CFG_DEAD_COLUMNS_BEGIN: r_cfg_dcb  <= i_cfg_data[7:0];
                CFG_DEAD_COLUMNS_END:   r_cfg_dce  <= i_cfg_data[7:0];
                CFG_DEAD_ROWS_BEGIN:    r_cfg_drb  <= i_cfg_data[7:0];
                CFG_DEAD_ROWS_END:      r_cfg_dre  <= i_cfg_data[7:0];
                CFG_BIN_COLUMNS:        r_cfg_binx <= i_cfg_data[4:0];
                CFG_BIN_ROWS:           r_cfg_biny <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_phase    <= PH_FLUSH_SHIFT;
            r_ws       <= '0;
            r_sub      <= '0;
            r_pat      <= '0;
            r_rc       <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_nib      <= '0;
            r_ocols    <= '0;
            r_orows    <= '0;
            r_groups   <= '0;
            r_width    <= '0;
            r_binx     <= '0;
            r_biny     <= '0;
            r_dcb      <= '0;
            r_dce      <= '0;
            r_drb      <= '0;
            r_pend_row <= '0;
            r_pend_col <= '0;
            r_pv       <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_mode   <= (i_func == FUNC_FLUSH) ? MODE_FLUSH : MODE_READ;
                r_phase  <= (i_func == FUNC_FLUSH) ? PH_FLUSH_SHIFT : PH_DEAD_SHIFT;
                r_binx   <= (r_cfg_binx == '0) ? 5'd1 : r_cfg_binx;
                r_biny   <= (r_cfg_biny == '0) ? 5'd1 : r_cfg_biny;
                r_dcb    <= r_cfg_dcb;
                r_dce    <= r_cfg_dce;
                r_drb    <= r_cfg_drb;
                r_width  <= cols_sat + {5'd0, r_cfg_dcb} + {5'd0, r_cfg_dce};
                r_groups <= q_grp + 14'(FLUSH_GROUP_LINES);
                r_row    <= '0;
                r_col    <= '0;
                r_ws     <= '0;
                r_sub    <= '0;
                r_pat    <= '0;
                r_rc     <= '0;
                r_nib    <= '0;
            end
            if (i_cmd.div_finish) begin
                r_ocols  <= q_cols[11:0];
                r_orows  <= q_rows[12:0];
            end
            if (i_cmd.step) begin
                r_pv <= 1'b0;
                case (r_rc)
                    3'd1: r_nib[3:0]  <= nib;
                    3'd2: r_nib[7:4]  <= nib;
                    3'd3: r_nib[11:8] <= nib;
                    3'd4: begin
                        r_pv   <= (r_pend_col != '0) || (r_pend_row != '0);
                        r_pval <= (pix_raw > PIX_MAX) ? 15'(PIX_MAX) : pix_raw[14:0];
                        r_pidx <= idx;
                        r_nib  <= '0;
                    end
                    default: ;
                endcase
                r_rc <= '0;
            end
            if (i_cmd.advance) begin
                r_col <= '0;
                r_ws  <= '0;
                r_sub <= '0;
                r_pat <= '0;
                if (skip_dead) begin
                    r_phase <= PH_ROW_SHIFT;
                    r_row   <= '0;
                end else begin
                    case (r_phase)
                        PH_FLUSH_LINE: begin
                            r_phase <= PH_FLUSH_SHIFT;
                            r_row   <= r_row + 14'd1;
                        end
                        PH_DEAD_LINE: begin
                            r_phase <= PH_DEAD_SHIFT;
                            r_row   <= r_row + 14'd1;
                        end
                        PH_DCE: begin
                            r_phase <= PH_ROW_SHIFT;
                            r_row   <= r_row + 14'd1;
                        end
                        default: r_phase <= r_phase + 3'd1;
                    endcase
                end
            end
            if (i_cmd.emit_done) begin
                r_mode <= MODE_IDLE;
            end
            if (i_cmd.emit_write) begin
                if (r_phase == PH_PIXEL && r_ws >= pix_base) begin
                    r_rc <= conv_off[2:0] + 3'd1;
                    if (conv_off[2:0] == 3'd0) begin
                        r_nib <= '0;
                    end
                    if (conv_off[2:0] == 3'd3) begin
                        r_pend_row <= r_row;
                        r_pend_col <= r_col;
                    end
                end
                if (ws_inc >= uwrites) begin
                    r_ws  <= '0;
                    r_sub <= '0;
                    r_pat <= '0;
                    r_col <= r_col + 14'd1;
                end else begin
                    r_ws <= ws_inc;
                    if (r_sub == 4'(PHASE_REPEAT - 1)) begin
                        r_sub <= '0;
                        r_pat <= r_pat + 3'd1;
                    end else begin
                        r_sub <= r_sub + 4'd1;
                    end
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit_plain || i_cmd.div_finish || i_cmd.emit_write
                     || i_cmd.emit_done) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_plain || i_cmd.div_finish || i_cmd.emit_write
            || i_cmd.emit_done) begin
            r_owrite <= i_cmd.emit_write;
            r_obyte  <= i_cmd.emit_write ? byte_now : 8'd0;
            r_odone  <= i_cmd.emit_done;
            r_obusy  <= i_cmd.emit_plain ? (r_mode != MODE_IDLE) : 1'b1;
            r_opv    <= (i_cmd.emit_write || i_cmd.emit_done) && r_pv;
            r_opval  <= ((i_cmd.emit_write || i_cmd.emit_done) && r_pv) ? r_pval : '0;
            r_opidx  <= ((i_cmd.emit_write || i_cmd.emit_done) && r_pv) ? r_pidx : '0;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_port_write    = r_owrite;
    assign o_port_byte     = r_obyte;
    assign o_pixel_valid   = r_opv;
    assign o_pixel_value   = r_opval;
    assign o_pixel_index   = r_opidx;
    assign o_busy_res      = r_obusy;
    assign o_sequence_done = r_odone;
endmodule
`default_nettype wire

FILE: hw/rtl/crs_ctrl.sv
// Controller state machine of the sequencer.
// Uses crs_pkg; drives the datapath through t_cmd and reads t_stat.
`default_nettype none
module crs_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic [1:0]     i_func,
    input  wire crs_pkg::t_stat i_stat,
    output logic                o_in_stall,
    output crs_pkg::t_cmd       o_cmd
);
    import crs_pkg::*;

    t_state r_state, n_state;
    logic   accept;

    assign accept     = i_in_valid && r_state == ST_IDLE && i_stat.out_free;
    assign o_in_stall = !(r_state == ST_IDLE && i_stat.out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_func == FUNC_STEP) begin
                        if (i_stat.active) n_state = ST_SETTLE;
                    end else if (i_func != FUNC_NONE && !i_stat.active) begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: if (!i_stat.div_busy) n_state = ST_IDLE;
            ST_SETTLE: if (i_stat.fin || i_stat.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_func == FUNC_STEP) begin
                        if (i_stat.active) o_cmd.step = 1'b1;
                        else o_cmd.emit_plain = 1'b1;
                    end else if (i_func != FUNC_NONE && !i_stat.active) begin
                        o_cmd.start = 1'b1;
                    end else begin
                        o_cmd.emit_plain = 1'b1;
                    end
                end
            end
            ST_DIV: o_cmd.div_finish = !i_stat.div_busy;
            ST_SETTLE: begin
                // walk past empty segments one per cycle
                if (i_stat.fin) o_cmd.emit_done = 1'b1;
                else if (i_stat.ready) o_cmd.emit_write = 1'b1;
                else o_cmd.advance = 1'b1;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire
